// ----- rtl/gdds_pkg.sv -----
// Package for the Gregorian date day stepper: operation codes, microcode
// word layout, the microprogram itself and the calendar helper functions.
// It depends on nothing and is compiled first.
package gdds_pkg;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2,
      OP_CMP  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_NOP,
      ACT_LOAD_YM,
      ACT_LOAD_D,
      ACT_ADD_INIT,
      ACT_ADD_STEP,
      ACT_SUB_INIT,
      ACT_SUB_STEP,
      ACT_CMP
   } dp_act_type;

   typedef enum logic [2:0] {
      JC_NEXT,
      JC_GOTO,
      JC_WAIT_REQ,
      JC_WHILE,
      JC_WAIT_OUT
   } jump_type;

   localparam int UPC_WIDTH = 4;
   typedef logic [UPC_WIDTH-1:0] upc_type;

   localparam upc_type STEP_IDLE      = 4'd0;
   localparam upc_type STEP_LOAD_YM   = 4'd1;
   localparam upc_type STEP_LOAD_WAIT = 4'd2;
   localparam upc_type STEP_LOAD_D    = 4'd3;
   localparam upc_type STEP_ADD_INIT  = 4'd4;
   localparam upc_type STEP_ADD_LOOP  = 4'd5;
   localparam upc_type STEP_SUB_INIT  = 4'd6;
   localparam upc_type STEP_SUB_LOOP  = 4'd7;
   localparam upc_type STEP_CMP       = 4'd8;
   localparam upc_type STEP_DONE      = 4'd9;

   typedef struct packed {
      dp_act_type act;
      jump_type   jc;
      upc_type    target;
      logic       take_req;
      logic       emit;
   } ucode_word_type;

   typedef struct packed {
      dp_act_type act;
      logic       take;
      logic       emit;
   } dp_ctrl_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] day_count;
      logic [4:0]  given_day;
      logic [3:0]  given_month;
      logic [15:0] given_year;
   } req_data_type;

   typedef struct packed {
      logic [4:0]  date_day;
      logic [3:0]  date_month;
      logic [15:0] date_year;
      logic        is_later;
      logic        is_equal;
      logic        year_wrapped;
   } rsp_data_type;

   // Multiplicative inverse of 25 modulo 2**16 and the largest image of a multiple of 25.
   localparam logic [15:0] INV25 = 16'h5C29;
   localparam logic [15:0] LIM25 = 16'd2621;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   function automatic logic is_leap(input logic [15:0] year);
      logic [15:0] image;
      logic        div25;
      image = year * INV25;
      div25 = (image <= LIM25);
      return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default:                                    len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic upc_type entry_step(input op_type op);
      upc_type step;
      unique case (op)
         OP_LOAD: step = STEP_LOAD_YM;
         OP_ADD:  step = STEP_ADD_INIT;
         OP_SUB:  step = STEP_SUB_INIT;
         default: step = STEP_CMP;
      endcase
      return step;
   endfunction

   function automatic ucode_word_type ucode(input upc_type upc);
      ucode_word_type w;
      unique case (upc)
         STEP_IDLE:      w = '{ACT_NOP,      JC_WAIT_REQ, STEP_IDLE, 1'b1, 1'b0};
         STEP_LOAD_YM:   w = '{ACT_LOAD_YM,  JC_NEXT,     STEP_IDLE, 1'b0, 1'b0};
         STEP_LOAD_WAIT: w = '{ACT_NOP,      JC_NEXT,     STEP_IDLE, 1'b0, 1'b0};
         STEP_LOAD_D:    w = '{ACT_LOAD_D,   JC_GOTO,     STEP_DONE, 1'b0, 1'b0};
         STEP_ADD_INIT:  w = '{ACT_ADD_INIT, JC_NEXT,     STEP_IDLE, 1'b0, 1'b0};
         STEP_ADD_LOOP:  w = '{ACT_ADD_STEP, JC_WHILE,    STEP_DONE, 1'b0, 1'b0};
         STEP_SUB_INIT:  w = '{ACT_SUB_INIT, JC_NEXT,     STEP_IDLE, 1'b0, 1'b0};
         STEP_SUB_LOOP:  w = '{ACT_SUB_STEP, JC_WHILE,    STEP_DONE, 1'b0, 1'b0};
         STEP_CMP:       w = '{ACT_CMP,      JC_GOTO,     STEP_DONE, 1'b0, 1'b0};
         STEP_DONE:      w = '{ACT_NOP,      JC_WAIT_OUT, STEP_IDLE, 1'b0, 1'b1};
         default:        w = '{ACT_NOP,      JC_GOTO,     STEP_IDLE, 1'b0, 1'b0};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/gdds_if.sv -----
// Handshake interfaces for the request and response channels of the date stepper.
// Both carry valid, ready and the payload fields; they depend on nothing else.
interface gdds_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] day_count;
   logic [4:0]  given_day;
   logic [3:0]  given_month;
   logic [15:0] given_year;

   modport source(output valid, operation, day_count, given_day, given_month, given_year,
                  input ready);
   modport sink(input valid, operation, day_count, given_day, given_month, given_year,
                output ready);
endinterface

interface gdds_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  date_day;
   logic [3:0]  date_month;
   logic [15:0] date_year;
   logic        is_later;
   logic        is_equal;
   logic        year_wrapped;

   modport source(output valid, date_day, date_month, date_year, is_later, is_equal,
                  year_wrapped, input ready);
   modport sink(input valid, date_day, date_month, date_year, is_later, is_equal,
                year_wrapped, output ready);
endinterface

// ----- rtl/gregorian_date_day_stepper_core.sv -----
// Top level of the Gregorian date day stepper: handshakes, sequencer and datapath.
// Depends on gdds_pkg, gdds_if, gdds_sequencer and gdds_datapath.
//
//   Channel    Modport  Direction  Contents
//   req_chan   sink     in         operation, day_count, given day, month, year
//   rsp_chan   source   out        stored date, is_later, is_equal, year_wrapped
//
// A load steps through loading year and month, a wait step and loading the day, a
// compare through a single compare step, and an add or subtract through an init step
// and the month loop of the microprogram, which repeats once per month crossed.
// Reset is synchronous and restores the date to January 1 of year 1.
// The response register lets the next request transfer while a result waits;
// a stalled response holds the sequencer in its final step.
module gregorian_date_day_stepper_core (
   input  logic       clock,
   input  logic       reset,
   gdds_req_if.sink   req_chan,
   gdds_rsp_if.source rsp_chan
);

   logic                   start;
   logic                   take_req;
   logic                   more;
   logic                   out_free;
   logic                   rsp_valid_ff, rsp_valid_in;
   gdds_pkg::dp_ctrl_type  ctrl;
   gdds_pkg::req_data_type req_data;
   gdds_pkg::rsp_data_type rsp_data;

   assign req_chan.ready = take_req;
   assign start          = req_chan.valid && take_req;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      req_data.operation   = req_chan.operation;
      req_data.day_count   = req_chan.day_count;
      req_data.given_day   = req_chan.given_day;
      req_data.given_month = req_chan.given_month;
      req_data.given_year  = req_chan.given_year;
   end

   gdds_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (gdds_pkg::op_type'(req_chan.operation)),
      .more      (more),
      .out_free  (out_free),
      .take_req  (take_req),
      .ctrl      (ctrl)
   );

   gdds_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .more     (more),
      .rsp_data (rsp_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.date_day     = rsp_data.date_day;
   assign rsp_chan.date_month   = rsp_data.date_month;
   assign rsp_chan.date_year    = rsp_data.date_year;
   assign rsp_chan.is_later     = rsp_data.is_later;
   assign rsp_chan.is_equal     = rsp_data.is_equal;
   assign rsp_chan.year_wrapped = rsp_data.year_wrapped;

endmodule

// ----- rtl/gdds_sequencer.sv -----
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on gdds_pkg for the control word layout and the microprogram.
module gdds_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  gdds_pkg::op_type      operation,
   input  logic                  more,
   input  logic                  out_free,
   output logic                  take_req,
   output gdds_pkg::dp_ctrl_type ctrl
);

   gdds_pkg::upc_type        upc_ff;
   gdds_pkg::upc_type        upc_in;
   gdds_pkg::ucode_word_type word;

   assign word = gdds_pkg::ucode(upc_ff);

   always_comb begin
      upc_in = upc_ff;
      unique case (word.jc)
         gdds_pkg::JC_NEXT:     upc_in = upc_ff + gdds_pkg::upc_type'(1);
         gdds_pkg::JC_GOTO:     upc_in = word.target;
         gdds_pkg::JC_WAIT_REQ: upc_in = start ? gdds_pkg::entry_step(operation) : upc_ff;
         gdds_pkg::JC_WHILE:    upc_in = more ? upc_ff : word.target;
         gdds_pkg::JC_WAIT_OUT: upc_in = out_free ? word.target : upc_ff;
         default:               upc_in = gdds_pkg::STEP_IDLE;
      endcase
   end

   always_comb begin
      take_req  = word.take_req;
      ctrl.act  = word.act;
      ctrl.take = start;
      ctrl.emit = word.emit && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= gdds_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ----- rtl/gdds_datapath.sv -----
// Datapath of the date stepper: stored date, day accumulator, leap flag,
// captured request fields and the response register. Depends on gdds_pkg.
module gdds_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  gdds_pkg::dp_ctrl_type  ctrl,
   input  gdds_pkg::req_data_type req_data,
   output logic                   more,
   output gdds_pkg::rsp_data_type rsp_data
);

   logic [4:0]         day_ff, day_in;
   logic [3:0]         month_ff, month_in;
   logic [15:0]        year_ff, year_in;
   logic               leap_ff;
   logic signed [17:0] acc_ff, acc_in;
   logic               later_ff, later_in;
   logic               equal_ff, equal_in;
   logic               wrap_ff, wrap_in;
   logic [15:0]        cnt_ff;
   logic [4:0]         gd_ff;
   logic [3:0]         gm_ff;
   logic [15:0]        gy_ff;
   gdds_pkg::rsp_data_type out_ff;

   logic [4:0]         len_cur;
   logic [3:0]         prev_month;
   logic [4:0]         len_prev;
   logic [3:0]         gm_fixed;
   logic               add_more;
   logic               sub_more;

   always_comb begin
      len_cur    = gdds_pkg::month_len(month_ff, leap_ff);
      prev_month = (month_ff <= gdds_pkg::MONTH_JAN) ? gdds_pkg::MONTH_DEC
                                                     : month_ff - 4'd1;
      len_prev   = gdds_pkg::month_len(prev_month, leap_ff);
      add_more   = acc_ff > $signed({13'd0, len_cur});
      sub_more   = acc_ff < 18'sd1;
      more       = (ctrl.act == gdds_pkg::ACT_ADD_STEP) ? add_more : sub_more;
      if (gm_ff < gdds_pkg::MONTH_JAN) begin
         gm_fixed = gdds_pkg::MONTH_JAN;
      end else if (gm_ff > gdds_pkg::MONTH_DEC) begin
         gm_fixed = gdds_pkg::MONTH_DEC;
      end else begin
         gm_fixed = gm_ff;
      end
   end

   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      acc_in   = acc_ff;
      later_in = later_ff;
      equal_in = equal_ff;
      wrap_in  = wrap_ff;
      unique case (ctrl.act)
         gdds_pkg::ACT_LOAD_YM: begin
            month_in = gm_fixed;
            year_in  = gy_ff;
         end
         gdds_pkg::ACT_LOAD_D: begin
            if (gd_ff == 5'd0) begin
               day_in = 5'd1;
            end else if (gd_ff > len_cur) begin
               day_in = len_cur;
            end else begin
               day_in = gd_ff;
            end
         end
         gdds_pkg::ACT_ADD_INIT: begin
            acc_in = $signed({13'd0, day_ff}) + $signed({2'd0, cnt_ff});
         end
         gdds_pkg::ACT_ADD_STEP: begin
            if (add_more) begin
               acc_in = acc_ff - $signed({13'd0, len_cur});
               if (month_ff >= gdds_pkg::MONTH_DEC) begin
                  month_in = gdds_pkg::MONTH_JAN;
                  year_in  = year_ff + 16'd1;
                  if (year_ff == 16'hFFFF) begin
                     wrap_in = 1'b1;
                  end
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               day_in = acc_ff[4:0];
            end
         end
         gdds_pkg::ACT_SUB_INIT: begin
            acc_in = $signed({13'd0, day_ff}) - $signed({2'd0, cnt_ff});
         end
         gdds_pkg::ACT_SUB_STEP: begin
            if (sub_more) begin
               acc_in   = acc_ff + $signed({13'd0, len_prev});
               month_in = prev_month;
               if (month_ff <= gdds_pkg::MONTH_JAN) begin
                  year_in = year_ff - 16'd1;
                  if (year_ff == 16'd0) begin
                     wrap_in = 1'b1;
                  end
               end
            end else begin
               day_in = acc_ff[4:0];
            end
         end
         gdds_pkg::ACT_CMP: begin
            later_in = {year_ff, month_ff, day_ff} > {gy_ff, gm_ff, gd_ff};
            equal_in = {year_ff, month_ff, day_ff} == {gy_ff, gm_ff, gd_ff};
         end
         default: begin
         end
      endcase
      if (ctrl.take) begin
         later_in = 1'b0;
         equal_in = 1'b0;
         wrap_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= 5'd1;
         month_ff <= 4'd1;
         year_ff  <= 16'd1;
         leap_ff  <= 1'b0;
      end else begin
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
         leap_ff  <= gdds_pkg::is_leap(year_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      later_ff <= later_in;
      equal_ff <= equal_in;
      wrap_ff  <= wrap_in;
      if (ctrl.take) begin
         cnt_ff <= req_data.day_count;
         gd_ff  <= req_data.given_day;
         gm_ff  <= req_data.given_month;
         gy_ff  <= req_data.given_year;
      end
      if (ctrl.emit) begin
         out_ff.date_day     <= day_ff;
         out_ff.date_month   <= month_ff;
         out_ff.date_year    <= year_ff;
         out_ff.is_later     <= later_ff;
         out_ff.is_equal     <= equal_ff;
         out_ff.year_wrapped <= wrap_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

// ----- rtl/gdds_checker.sv -----
// Port-level checker for the date stepper and the bind that attaches it to the top level.
// Depends on gregorian_date_day_stepper_core and its channel interfaces.
module gdds_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_date_day,
   input logic [3:0]  rsp_date_month,
   input logic [15:0] rsp_date_year,
   input logic        rsp_is_later,
   input logic        rsp_is_equal,
   input logic        rsp_year_wrapped
);

   logic [27:0] rsp_word;

   assign rsp_word = {rsp_date_day, rsp_date_month, rsp_date_year,
                      rsp_is_later, rsp_is_equal, rsp_year_wrapped};

   // A response that is not taken stays offered unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response changed or dropped");

   // Reset leaves no response offered.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered after reset");

   // Every reported date has a month from 1 to 12 and a nonzero day within the longest length of that month.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_date_month >= 4'd1 && rsp_date_month <= 4'd12 &&
                    rsp_date_day != 5'd0 &&
                    (rsp_date_month != 4'd2 || rsp_date_day <= 5'd29) &&
                    ((rsp_date_month != 4'd4 && rsp_date_month != 4'd6 &&
                      rsp_date_month != 4'd9 && rsp_date_month != 4'd11) ||
                     rsp_date_day <= 5'd30))
      else $error("response date out of range");

   // Later and equal exclude each other.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_later && rsp_is_equal))
      else $error("later and equal both set");

   // Compare flags and the wrap flag come from different operations.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_is_later || rsp_is_equal) |-> !rsp_year_wrapped)
      else $error("wrap flag set on a compare result");

endmodule

bind gregorian_date_day_stepper_core gdds_checker u_gdds_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_date_day     (rsp_chan.date_day),
   .rsp_date_month   (rsp_chan.date_month),
   .rsp_date_year    (rsp_chan.date_year),
   .rsp_is_later     (rsp_chan.is_later),
   .rsp_is_equal     (rsp_chan.is_equal),
   .rsp_year_wrapped (rsp_chan.year_wrapped)
);
